FILE: rtl/b16vc_pkg.sv
// ----------------------------------------------------------------------------
// b16vc_pkg
// Shared types, tables and helper functions for the base-16 check character
// block built on the dihedral group D8.
// ----------------------------------------------------------------------------
package b16vc_pkg;

   // ascii codes used by the character mapping
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_NONE    = 8'h00;
   localparam logic [3:0] LETTER_BASE  = 4'd10;

   // one input item
   typedef struct packed {
      logic [7:0] symbol;
      logic       begin_string;
      logic       end_string;
      logic [7:0] expected_check;
   } req_type;

   // one result item
   typedef struct packed {
      logic [7:0] check_symbol;
      logic       check_matches;
      logic       bad_symbol_seen;
   } rsp_type;

   // mapping result of one character
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } sym_type;

   typedef logic [15:0][3:0]        perm_type;
   typedef logic [15:0][15:0][3:0]  perm_pow_type;

   // base permutation
   localparam perm_type PERM16 = {4'd1, 4'd9, 4'd6, 4'd10, 4'd13, 4'd3, 4'd11, 4'd2,
                                  4'd0, 4'd15, 4'd12, 4'd8, 4'd14, 4'd5, 4'd7, 4'd4};

   // table of the permutation applied n times, built at elaboration
   function automatic perm_pow_type build_perm_pow();
      perm_pow_type tbl;
      logic [3:0]   p;
      for (int n = 0; n < 16; n++) begin
         for (int v = 0; v < 16; v++) begin
            p = v[3:0];
            for (int k = 0; k < n; k++) begin
               p = PERM16[p];
            end
            tbl[n][v] = p;
         end
      end
      return tbl;
   endfunction

   localparam perm_pow_type PERM_POW = build_perm_pow();

   // ascii hex character to value
   function automatic sym_type sym_decode(input logic [7:0] ch);
      sym_type s;
      logic [7:0] d;
      s = '0;
      d = '0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         d = ch - CHAR_ZERO;
         s.valid = 1'b1;
         s.value = d[3:0];
      end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) begin
         d = ch - CHAR_UPPER_A;
         s.valid = 1'b1;
         s.value = d[3:0] + LETTER_BASE;
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F) begin
         d = ch - CHAR_LOWER_A;
         s.valid = 1'b1;
         s.value = d[3:0] + LETTER_BASE;
      end
      return s;
   endfunction

   // d8 product: low half rotations, high half reflections
   function automatic logic [3:0] d8_mul(input logic [3:0] x, input logic [3:0] y);
      logic [2:0] r;
      if (!x[3]) begin
         r = x[2:0] + y[2:0];
      end else begin
         r = x[2:0] - y[2:0];
      end
      return {x[3] ^ y[3], r};
   endfunction

   // d8 inverse: rotations negate, reflections are their own inverse
   function automatic logic [3:0] d8_inv(input logic [3:0] c);
      logic [2:0] r;
      r = 3'd0 - c[2:0];
      return c[3] ? c : {1'b0, r};
   endfunction

   // value to uppercase ascii hex
   function automatic logic [7:0] hex_char(input logic [3:0] c);
      logic [7:0] ch;
      if (c < LETTER_BASE) begin
         ch = CHAR_ZERO + {4'd0, c};
      end else begin
         ch = CHAR_UPPER_A + {4'd0, c - LETTER_BASE};
      end
      return ch;
   endfunction

endpackage

FILE: rtl/base16_verhoeff_check_char.sv
// ----------------------------------------------------------------------------
// base16_verhoeff_check_char
// Folds a hex string, last character first, into a D8 check value and
// returns the uppercase check character and a compare flag at string end.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | req_data (symbol, begin, end, expected)
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_data (check char, match, bad flag)
//
//  one character per cycle sustained unless a stalled result holds back an end
//  character; the result register and its valid bit load as the end character leaves in_ff
//  the permutation power is a 256-entry constant table read in one step
//  reset is synchronous and clears valid bits and the running check state
//  a stalled result only holds back end characters; others keep flowing
// ----------------------------------------------------------------------------
module base16_verhoeff_check_char (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  b16vc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output b16vc_pkg::rsp_type rsp_data
);
   import b16vc_pkg::*;

   logic       in_vld_ff, in_vld_in;
   req_type    in_ff;
   logic       out_vld_ff, out_vld_in;
   rsp_type    out_ff, out_in;
   logic [3:0] acc_ff, acc_in;
   logic [3:0] pos_ff, pos_in;
   logic       err_ff, err_in;

   logic       in_adv;
   logic       out_free;
   logic [3:0] acc_base, pos_base;
   logic       err_base;
   sym_type    sym;
   logic [3:0] perm_val;
   logic [3:0] check_val;

   // flow control
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign in_adv    = in_vld_ff && (!in_ff.end_string || out_free);
   assign req_stall = in_vld_ff && !in_adv;
   assign in_vld_in = req_valid && !req_stall ? 1'b1 : (in_adv ? 1'b0 : in_vld_ff);

   // running state update
   always_comb begin
      acc_base  = in_ff.begin_string ? 4'd0 : acc_ff;
      pos_base  = in_ff.begin_string ? 4'd0 : pos_ff;
      err_base  = in_ff.begin_string ? 1'b0 : err_ff;
      sym       = sym_decode(in_ff.symbol);
      pos_in    = pos_base + 4'd1;
      perm_val  = PERM_POW[pos_in][sym.value];
      acc_in    = sym.valid ? d8_mul(acc_base, perm_val) : acc_base;
      err_in    = err_base || !sym.valid;
      check_val = d8_inv(acc_in);
   end

   // result formation
   always_comb begin
      out_in.check_symbol    = err_in ? CHAR_NONE : hex_char(check_val);
      out_in.check_matches   = (out_in.check_symbol == in_ff.expected_check);
      out_in.bad_symbol_seen = err_in;
      if (in_adv && in_ff.end_string) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         acc_ff     <= 4'd0;
         pos_ff     <= 4'd0;
         err_ff     <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (in_adv) begin
            acc_ff <= acc_in;
            pos_ff <= pos_in;
            err_ff <= err_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
      if (in_adv && in_ff.end_string) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // a new result only follows an end character leaving the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(in_adv && in_ff.end_string))
      else $error("result appeared without an end transfer");

   // begin restarts the position count at one
   a_begin_pos: assert property (@(posedge clock) disable iff (reset)
      in_adv && in_ff.begin_string |=> pos_ff == 4'd1)
      else $error("position not restarted on begin");

   // the check character is zero exactly when a bad character was seen
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> ((out_ff.check_symbol == CHAR_NONE) == out_ff.bad_symbol_seen))
      else $error("check character and bad flag disagree");

   // a held input item keeps its contents
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !in_adv |=> in_vld_ff && $stable(in_ff))
      else $error("held input item lost or changed");

endmodule
